FILE: sv/crc8flr_pkg.sv
// Shared types, constants and the CRC-8 helper for the framed link receiver.
package crc8flr_pkg;

    // Frame geometry: the fields span nine payload bytes at most.
    localparam int PAYLOAD_BYTES_DEF = 9;
    localparam int FIELD_BYTES       = 9;

    // Configuration register reset values.
    localparam logic [7:0]  HDR_FIRST_RST  = 8'd165;
    localparam logic [7:0]  HDR_SECOND_RST = 8'd90;
    localparam logic [15:0] TIMEOUT_RST    = 16'd50;

    // Configuration register indexes.
    localparam logic [1:0] CFG_HDR_FIRST  = 2'd0;
    localparam logic [1:0] CFG_HDR_SECOND = 2'd1;
    localparam logic [1:0] CFG_TIMEOUT    = 2'd2;

    localparam logic [7:0] CRC_POLY   = 8'h07;
    localparam logic [7:0] FIRST_TASK = 8'hFF;

    // Request codes on the input stream.
    localparam logic [1:0] REQ_BYTE = 2'd0;
    localparam logic [1:0] REQ_TICK = 2'd1;
    localparam logic [1:0] REQ_TAKE = 2'd2;

    // Event codes on the result stream.
    localparam logic [1:0] EV_NONE    = 2'd0;
    localparam logic [1:0] EV_FRAME   = 2'd1;
    localparam logic [1:0] EV_CRC_ERR = 2'd2;
    localparam logic [1:0] EV_TIMEOUT = 2'd3;

    localparam int IN_DATA_W  = 8;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 128;
    localparam int OUT_USER_W = 2;

    // Operation classes handed from the front to the back.
    typedef enum logic [1:0] {
        OP_NOP  = 2'd0,
        OP_BYTE = 2'd1,
        OP_TICK = 2'd2,
        OP_TAKE = 2'd3
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] rx_byte;
    } t_queue_item;

    typedef struct packed {
        logic [7:0]  hdr_first;
        logic [7:0]  hdr_second;
        logic [15:0] timeout_limit;
    } t_cfg;

    // Feed one byte into a CRC-8, MSB first, no reflection.
    function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

FILE: sv/crc8flr_front.sv
// Front end: accepts items, classifies the request and queues it for the back end.
module crc8flr_front
    import crc8flr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [IN_DATA_W-1:0] s_axis_tdata,  // [7:0] rx_byte
    input  logic [IN_USER_W-1:0] s_axis_tuser,  // [1:0] req_type
    output logic                 o_q_valid,
    input  logic                 i_q_pop,
    output t_queue_item          o_q_item
);

    t_queue_item r_q [0:1];
    logic        r_wr_ptr;
    logic        r_rd_ptr;
    logic [1:0]  r_count;
    logic        w_push;
    logic        w_pop;
    t_queue_item w_item;

    always_comb begin
        w_item.rx_byte = s_axis_tdata[7:0];
        case (s_axis_tuser)
            REQ_BYTE: w_item.op = OP_BYTE;
            REQ_TICK: w_item.op = OP_TICK;
            REQ_TAKE: w_item.op = OP_TAKE;
            default:  w_item.op = OP_NOP;
        endcase
    end

    assign s_axis_tready = (r_count != 2'd2);
    assign w_push        = s_axis_tvalid && s_axis_tready;
    assign o_q_valid     = (r_count != 2'd0);
    assign w_pop         = i_q_pop && o_q_valid;
    assign o_q_item      = r_q[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

FILE: sv/crc8flr_back.sv
// Back end: framer, CRC check, field latch, link state and the result register.
module crc8flr_back
    import crc8flr_pkg::*;
#(
    parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cfg                  i_cfg,
    input  logic                  i_q_valid,
    output logic                  o_q_pop,
    input  t_queue_item           i_q_item,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    output logic [OUT_USER_W-1:0] m_axis_tuser
);

    localparam int POS_W = $clog2(PAYLOAD_BYTES + 1);
    localparam int IDX_W = $clog2(PAYLOAD_BYTES);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_HDR2 = 2'd1;
    localparam logic [1:0] PH_DATA = 2'd2;
    localparam logic [1:0] PH_CRC  = 2'd3;

    logic [1:0]       r_phase, n_phase;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [7:0]       r_crc, n_crc;
    logic [7:0]       r_store [0:PAYLOAD_BYTES-1];
    logic [7:0]       w_pay [0:FIELD_BYTES-1];
    logic             w_store_we;

    logic [7:0]  r_task, n_task;
    logic [7:0]  r_vstate, n_vstate;
    logic [15:0] r_posn, n_posn;
    logic [15:0] r_vel, n_vel;
    logic [15:0] r_tgt, n_tgt;
    logic [7:0]  r_seq, n_seq;
    logic [7:0]  r_prev_task, n_prev_task;
    logic [15:0] r_switches, n_switches;
    logic [31:0] r_frames, n_frames;
    logic [15:0] r_ticks, n_ticks;
    logic        r_fresh, n_fresh;
    logic        r_tout, n_tout;
    logic        r_changed, n_changed;

    logic [1:0]  w_event;
    logic        w_fresh_out;
    logic        w_data_ok;
    logic [7:0]  w_crc_next;
    logic [7:0]  w_byte;

    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic [OUT_USER_W-1:0] r_out_user;

    // Fields beyond a short payload read as zero.
    generate
        for (genvar k = 0; k < FIELD_BYTES; k++) begin : g_pay
            if (k < PAYLOAD_BYTES) begin : g_on
                assign w_pay[k] = r_store[k];
            end else begin : g_off
                assign w_pay[k] = 8'd0;
            end
        end
    endgenerate

    assign o_q_pop    = i_q_valid && (!r_out_valid || m_axis_tready);
    assign w_byte     = i_q_item.rx_byte;
    assign w_crc_next = crc8_feed(r_crc, w_byte);

    always_comb begin
        n_phase     = r_phase;
        n_pos       = r_pos;
        n_crc       = r_crc;
        n_task      = r_task;
        n_vstate    = r_vstate;
        n_posn      = r_posn;
        n_vel       = r_vel;
        n_tgt       = r_tgt;
        n_seq       = r_seq;
        n_prev_task = r_prev_task;
        n_switches  = r_switches;
        n_frames    = r_frames;
        n_ticks     = r_ticks;
        n_fresh     = r_fresh;
        n_tout      = r_tout;
        n_changed   = r_changed;
        w_store_we  = 1'b0;
        w_event     = EV_NONE;

        case (i_q_item.op)
            OP_BYTE: begin
                case (r_phase)
                    PH_IDLE: begin
                        if (w_byte == i_cfg.hdr_first) begin
                            n_phase = PH_HDR2;
                        end
                    end
                    PH_HDR2: begin
                        if (w_byte == i_cfg.hdr_second) begin
                            n_phase = PH_DATA;
                            n_pos   = '0;
                            n_crc   = 8'd0;
                        end else begin
                            n_phase = PH_IDLE;
                        end
                    end
                    PH_DATA: begin
                        w_store_we = 1'b1;
                        n_crc      = w_crc_next;
                        n_pos      = r_pos + POS_W'(1);
                        if (n_pos >= POS_W'(PAYLOAD_BYTES)) begin
                            n_phase = PH_CRC;
                        end
                    end
                    default: begin
                        if (r_crc == w_byte) begin
                            w_event  = EV_FRAME;
                            n_task   = w_pay[0];
                            n_vstate = w_pay[1];
                            n_posn   = {w_pay[2], w_pay[3]};
                            n_vel    = {w_pay[4], w_pay[5]};
                            n_tgt    = {w_pay[6], w_pay[7]};
                            n_seq    = w_pay[8];
                            // Count a switch only once a first task is on record.
                            if (r_prev_task != w_pay[0]) begin
                                if (r_prev_task != FIRST_TASK) begin
                                    n_changed  = 1'b1;
                                    n_switches = r_switches + 16'd1;
                                end
                                n_prev_task = w_pay[0];
                            end
                            if (r_frames != 32'hFFFF_FFFF) begin
                                n_frames = r_frames + 32'd1;
                            end
                            n_fresh = 1'b1;
                            n_ticks = 16'd0;
                            n_tout  = 1'b0;
                        end else begin
                            w_event = EV_CRC_ERR;
                        end
                        n_phase = PH_IDLE;
                        n_pos   = '0;
                    end
                endcase
            end
            OP_TICK: begin
                if (r_ticks < i_cfg.timeout_limit) begin
                    n_ticks = r_ticks + 16'd1;
                end else if (!r_tout) begin
                    n_tout  = 1'b1;
                    n_fresh = 1'b0;
                    w_event = EV_TIMEOUT;
                end
            end
            default: begin
            end
        endcase

        if (i_q_item.op == OP_TAKE) begin
            w_fresh_out = r_fresh && (r_frames != 32'd0) && !r_tout;
            if (w_fresh_out) begin
                n_fresh = 1'b0;
            end
        end else begin
            w_fresh_out = n_fresh;
        end
        w_data_ok = (n_frames != 32'd0) && !n_tout;
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop && w_store_we) begin
            r_store[r_pos[IDX_W-1:0]] <= w_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_pos       <= '0;
            r_crc       <= 8'd0;
            r_task      <= 8'd0;
            r_vstate    <= 8'd0;
            r_posn      <= 16'd0;
            r_vel       <= 16'd0;
            r_tgt       <= 16'd0;
            r_seq       <= 8'd0;
            r_prev_task <= FIRST_TASK;
            r_switches  <= 16'd0;
            r_frames    <= 32'd0;
            r_ticks     <= 16'd0;
            r_fresh     <= 1'b0;
            r_tout      <= 1'b0;
            r_changed   <= 1'b0;
        end else if (o_q_pop) begin
            r_phase     <= n_phase;
            r_pos       <= n_pos;
            r_crc       <= n_crc;
            r_task      <= n_task;
            r_vstate    <= n_vstate;
            r_posn      <= n_posn;
            r_vel       <= n_vel;
            r_tgt       <= n_tgt;
            r_seq       <= n_seq;
            r_prev_task <= n_prev_task;
            r_switches  <= n_switches;
            r_frames    <= n_frames;
            r_ticks     <= n_ticks;
            r_fresh     <= n_fresh;
            r_tout      <= n_tout;
            r_changed   <= n_changed;
        end
    end

    // Result register: hold until taken, reload on the same edge it empties.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_q_pop) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_out_user <= w_event;
            r_out_data <= {5'd0, n_frames, w_data_ok, w_fresh_out, n_switches, n_changed,
                           n_seq, n_tgt, n_vel, n_posn, n_vstate, n_task};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

endmodule

FILE: sv/crc8_frame_link_receiver_core.sv
// Top level of the CRC-8 framed link receiver: config registers, front end and back end.
//
// Each input item is a request: a received byte (tuser 0), a 10 ms tick (tuser 1) or a
// take-fresh request (tuser 2); tuser 3 does nothing. Every item yields exactly one result
// item carrying an event code in tuser (0 none, 1 frame accepted, 2 CRC mismatch,
// 3 timeout declared) and the latched frame fields plus link status in tdata. A frame is
// header_first, header_second, PAYLOAD_BYTES payload bytes and a CRC-8 byte (poly 0x07,
// init 0, MSB first) taken over the payload. Throughput is one item per clock while
// the result side does not stall: a 2-entry queue sits behind the input handshake
// and the back end updates all state and loads the result register together as it
// pops an item, so a result passes through the queue and then the result register. The
// result register reloads on the same edge it is taken, so output backpressure stalls the
// input only once the queue fills. Configuration writes are always ready; write them only
// while no item is in flight.
module crc8_frame_link_receiver_core
    import crc8flr_pkg::*;
#(
    parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Input stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic [IN_USER_W-1:0]  s_axis_tuser,   // [1:0] req_type
    // Result stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [7:0] task id, [15:8] state byte, [31:16] position, [47:32] velocity,
    // [63:48] target, [71:64] sequence byte, [72] switch flag, [88:73] task_switches,
    // [89] fresh, [90] data_ok, [122:91] good_frames, [127:123] zero
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    output logic [OUT_USER_W-1:0] m_axis_tuser,   // [1:0] event_code
    // Configuration write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [1:0]            i_cfg_index,
    input  logic [15:0]           i_cfg_data
);

    t_cfg        r_cfg;
    logic        w_q_valid;
    logic        w_q_pop;
    t_queue_item w_q_item;

    assign o_cfg_ready = 1'b1;

    // Register file: an unknown index is dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hdr_first     <= HDR_FIRST_RST;
            r_cfg.hdr_second    <= HDR_SECOND_RST;
            r_cfg.timeout_limit <= TIMEOUT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_HDR_FIRST:  r_cfg.hdr_first     <= i_cfg_data[7:0];
                CFG_HDR_SECOND: r_cfg.hdr_second    <= i_cfg_data[7:0];
                CFG_TIMEOUT:    r_cfg.timeout_limit <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Accept and classify requests into the queue.
    crc8flr_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .o_q_valid     (w_q_valid),
        .i_q_pop       (w_q_pop),
        .o_q_item      (w_q_item)
    );

    // Execute requests and present results.
    crc8flr_back #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_q_valid     (w_q_valid),
        .o_q_pop       (w_q_pop),
        .i_q_item      (w_q_item),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

FILE: bench/crc8_frame_link_receiver_core_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for the CRC-8 framed link receiver core.
module crc8_frame_link_receiver_core_tb;
    import crc8flr_pkg::*;

    localparam int PAYLOAD_N    = PAYLOAD_BYTES_DEF;
    localparam int LIMIT_CYCLES = 300000;
    localparam int HOLD_CYCLES  = 300;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    typedef enum logic [1:0] {FR_IDLE, FR_HDR2, FR_DATA, FR_CRC} t_frame_phase;

    typedef struct packed {
        logic [1:0] req;
        logic [7:0] rx;
    } t_link_req;

    typedef struct packed {
        logic [7:0]         task_id;
        logic [7:0]         vstate;
        logic signed [15:0] position;
        logic signed [15:0] velocity;
        logic signed [15:0] target;
        logic [7:0]         seq;
    } t_frame_fields;

    typedef struct packed {
        logic [1:0]    ev;
        t_frame_fields f;
        logic          switch_flag;
        logic [15:0]   task_switches;
        logic          fresh;
        logic          data_ok;
        logic [31:0]   good_frames;
    } t_link_report;

    // DUT ports; every input starts at a known value
    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;   // [7:0] rx_byte
    logic [IN_USER_W-1:0]  s_axis_tuser  = '0;   // [1:0] req_type
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [OUT_USER_W-1:0] m_axis_tuser;         // [1:0] event_code
    logic                  i_cfg_valid   = 1'b0;
    logic                  o_cfg_ready;
    logic [1:0]            i_cfg_index   = '0;
    logic [15:0]           i_cfg_data    = '0;

    crc8_frame_link_receiver_core #(
        .PAYLOAD_BYTES(PAYLOAD_N)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Mirror of the receiver: configuration, framer and link status
    logic [7:0]    hdr1      = HDR_FIRST_RST;
    logic [7:0]    hdr2      = HDR_SECOND_RST;
    logic [15:0]   tmo_limit = TIMEOUT_RST;
    t_frame_phase  fr_phase  = FR_IDLE;
    logic [7:0]    payload [0:FIELD_BYTES-1];
    logic [3:0]    pay_idx   = '0;
    logic [7:0]    crc_acc   = '0;
    t_frame_fields lat       = '0;
    logic [7:0]    prev_task = FIRST_TASK;
    logic [15:0]   sw_count  = '0;
    logic [31:0]   good_count = '0;
    logic [15:0]   idle_ticks = '0;
    logic          fresh_flag = 1'b0;
    logic          link_down  = 1'b0;
    logic          sw_seen    = 1'b0;

    // Traffic and bookkeeping
    t_link_req    req_backlog[$];
    t_link_report due_reports[$];
    int  queued       = 0;
    int  results_seen = 0;
    int  mismatches   = 0;
    int  ev_seen [4]  = '{0, 0, 0, 0};
    int  cycle_cnt    = 0;
    bit  in_taken     = 1'b0;
    bit  out_taken    = 1'b0;
    bit  src_calm     = 1'b0;
    bit  sink_calm    = 1'b0;
    int  src_wait     = 0;
    int  sink_wait    = 0;
    int  hold_left    = 0;
    int  hold_requests = 0;
    int  holds_served  = 0;

    // CRC-8, polynomial 0x07, MSB first
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            c = c[7] ? ({c[6:0], 1'b0} ^ 8'h07) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

    // Bytes past the configured payload read as zero
    function automatic logic [7:0] byte_at(input int k);
        return (k < PAYLOAD_N) ? payload[k] : 8'h00;
    endfunction

    // Advance the mirror by one request and return the report it must produce
    function automatic t_link_report predict_link_report(input logic [1:0] req,
                                                         input logic [7:0] b);
        t_link_report r;
        logic [1:0]   ev;
        logic         fr;
        ev = EV_NONE;
        if (req == REQ_BYTE) begin
            case (fr_phase)
                FR_IDLE: begin
                    if (b == hdr1) fr_phase = FR_HDR2;
                end
                FR_HDR2: begin
                    // any other byte drops back to idle, even the first header again
                    if (b == hdr2) begin
                        fr_phase = FR_DATA;
                        pay_idx  = '0;
                        crc_acc  = '0;
                    end else begin
                        fr_phase = FR_IDLE;
                    end
                end
                FR_DATA: begin
                    if (pay_idx < FIELD_BYTES) payload[pay_idx] = b;
                    crc_acc = crc8_step(crc_acc, b);
                    pay_idx = pay_idx + 4'd1;
                    if (pay_idx >= PAYLOAD_N) fr_phase = FR_CRC;
                end
                default: begin
                    if (crc_acc == b) begin
                        lat.task_id  = byte_at(0);
                        lat.vstate   = byte_at(1);
                        lat.position = {byte_at(2), byte_at(3)};
                        lat.velocity = {byte_at(4), byte_at(5)};
                        lat.target   = {byte_at(6), byte_at(7)};
                        lat.seq      = byte_at(8);
                        // the first frame after reset only records its task id
                        if (prev_task != lat.task_id) begin
                            if (prev_task != FIRST_TASK) begin
                                sw_seen  = 1'b1;
                                sw_count = sw_count + 16'd1;
                            end
                            prev_task = lat.task_id;
                        end
                        if (good_count != 32'hFFFF_FFFF) good_count = good_count + 32'd1;
                        fresh_flag = 1'b1;
                        idle_ticks = '0;
                        link_down  = 1'b0;
                        ev = EV_FRAME;
                    end else begin
                        ev = EV_CRC_ERR;
                    end
                    fr_phase = FR_IDLE;
                    pay_idx  = '0;
                end
            endcase
        end else if (req == REQ_TICK) begin
            if (idle_ticks < tmo_limit) begin
                idle_ticks = idle_ticks + 16'd1;
            end else if (!link_down) begin
                link_down  = 1'b1;
                fresh_flag = 1'b0;
                ev = EV_TIMEOUT;
            end
        end

        if (req == REQ_TAKE) begin
            fr = fresh_flag && (good_count != 0) && !link_down;
            if (fr) fresh_flag = 1'b0;
        end else begin
            fr = fresh_flag;
        end

        ev_seen[ev]++;
        r.ev            = ev;
        r.f             = lat;
        r.switch_flag   = sw_seen;
        r.task_switches = sw_count;
        r.fresh         = fr;
        r.data_ok       = (good_count != 0) && !link_down;
        r.good_frames   = good_count;
        return r;
    endfunction

    task automatic cmp_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("result %0d: %s expected 0x%0h, got 0x%0h",
                         results_seen, name, want, got);
        end
    endtask

    // Rising edge: check the result first, then predict the newly accepted item.
    // A result can never belong to an item accepted on the same edge.
    always @(posedge i_clk) begin : link_tracker
        t_link_report want;
        t_link_report got;
        in_taken  = i_rst_n && s_axis_tvalid && s_axis_tready;
        out_taken = i_rst_n && m_axis_tvalid && m_axis_tready;
        if (out_taken) begin
            got.ev            = m_axis_tuser;
            got.f.task_id     = m_axis_tdata[7:0];
            got.f.vstate      = m_axis_tdata[15:8];
            got.f.position    = m_axis_tdata[31:16];
            got.f.velocity    = m_axis_tdata[47:32];
            got.f.target      = m_axis_tdata[63:48];
            got.f.seq         = m_axis_tdata[71:64];
            got.switch_flag   = m_axis_tdata[72];
            got.task_switches = m_axis_tdata[88:73];
            got.fresh         = m_axis_tdata[89];
            got.data_ok       = m_axis_tdata[90];
            got.good_frames   = m_axis_tdata[122:91];
            results_seen++;
            if (due_reports.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d arrived with nothing expected", results_seen);
            end else begin
                want = due_reports.pop_front();
                cmp_field("event_code",    32'(want.ev),            32'(got.ev));
                cmp_field("task_id",       32'(want.f.task_id),     32'(got.f.task_id));
                cmp_field("vstate",        32'(want.f.vstate),      32'(got.f.vstate));
                cmp_field("position",      32'(want.f.position),    32'(got.f.position));
                cmp_field("velocity",      32'(want.f.velocity),    32'(got.f.velocity));
                cmp_field("target",        32'(want.f.target),      32'(got.f.target));
                cmp_field("seq_byte",      32'(want.f.seq),         32'(got.f.seq));
                cmp_field("switch_flag",   32'(want.switch_flag),   32'(got.switch_flag));
                cmp_field("task_switches", 32'(want.task_switches), 32'(got.task_switches));
                cmp_field("fresh",         32'(want.fresh),         32'(got.fresh));
                cmp_field("data_ok",       32'(want.data_ok),       32'(got.data_ok));
                cmp_field("good_frames",   want.good_frames,        got.good_frames);
            end
        end
        if (in_taken) due_reports.push_back(predict_link_report(s_axis_tuser, s_axis_tdata));
        if (i_rst_n && i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_HDR_FIRST:  hdr1 = i_cfg_data[7:0];
                CFG_HDR_SECOND: hdr2 = i_cfg_data[7:0];
                CFG_TIMEOUT:    tmo_limit = i_cfg_data;
                default: ;
            endcase
        end
    end

    // Source: present the next pending item after a random gap
    always @(negedge i_clk) begin : item_source
        t_link_req nxt;
        if (i_rst_n) begin
            if (s_axis_tvalid && in_taken) src_wait = src_calm ? 0 : $urandom_range(0, 10);
            if (!s_axis_tvalid || in_taken) begin
                if (src_wait > 0) begin
                    src_wait--;
                    s_axis_tvalid <= 1'b0;
                end else if (req_backlog.size() > 0) begin
                    nxt = req_backlog.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser  <= nxt.req;
                    s_axis_tdata  <= nxt.rx;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Sink: stall a random number of cycles per result, plus long holds on request
    always @(negedge i_clk) begin : result_sink
        if (hold_requests > holds_served) begin
            holds_served++;
            hold_left = HOLD_CYCLES;
        end
        if (out_taken) sink_wait = sink_calm ? 0 : $urandom_range(0, 10);
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (sink_wait > 0) begin
            sink_wait--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Give up on a hung run
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > LIMIT_CYCLES) begin
            $display("Run stopped after %0d cycles with %0d results still due",
                     cycle_cnt, due_reports.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic queue_item(input logic [1:0] req, input logic [7:0] b);
        req_backlog.push_back(t_link_req'({req, b}));
        queued++;
    endtask

    // Queue a frame with the current headers; stop after cut payload bytes
    // when cut is short, and spoil the CRC byte on request.
    task automatic queue_frame(input logic [71:0] pl, input bit crc_bad, input int cut);
        logic [7:0] c;
        logic [7:0] b;
        c = '0;
        queue_item(REQ_BYTE, hdr1);
        queue_item(REQ_BYTE, hdr2);
        for (int k = 0; k < PAYLOAD_N; k++) begin
            if (k == cut) return;
            b = pl[8*k +: 8];
            // ticks and takes may arrive between payload bytes
            if ($urandom_range(0, 19) == 0)
                queue_item($urandom_range(0, 1) ? REQ_TICK : REQ_TAKE, 8'($urandom));
            queue_item(REQ_BYTE, b);
            c = crc8_step(c, b);
        end
        queue_item(REQ_BYTE, crc_bad ? (c ^ 8'($urandom_range(1, 255))) : c);
    endtask

    // Mostly well-formed frames with random content, the rest ticks, takes,
    // broken frames and line noise.
    task automatic queue_random(input int n);
        int         stop;
        int         pick;
        logic [7:0] tid;
        logic [7:0] b;
        logic [71:0] pl;
        stop = queued + n;
        while (queued < stop) begin
            pick = $urandom_range(0, 99);
            case ($urandom_range(0, 4))
                0:       tid = 8'h00;
                1:       tid = 8'h01;
                2:       tid = FIRST_TASK;
                3:       tid = 8'($urandom_range(0, 3));
                default: tid = 8'($urandom);
            endcase
            pl = {8'($urandom), 32'($urandom), 32'($urandom)};
            if ($urandom_range(0, 3) == 0)
                pl[8*$urandom_range(1, 8) +: 8] = $urandom_range(0, 1) ? 8'h80 : 8'h7F;
            pl[7:0] = tid;
            if (pick < 55) begin
                queue_frame(pl, 1'b0, PAYLOAD_N);
            end else if (pick < 65) begin
                queue_frame(pl, 1'b1, PAYLOAD_N);
            end else if (pick < 72) begin
                queue_frame(pl, 1'b0, $urandom_range(0, PAYLOAD_N - 1));
            end else if (pick < 77) begin
                b = hdr2 ^ 8'($urandom_range(1, 255));
                if ($urandom_range(0, 1) && hdr1 != hdr2) b = hdr1;
                queue_item(REQ_BYTE, hdr1);
                queue_item(REQ_BYTE, b);
            end else if (pick < 88) begin
                repeat ($urandom_range(1, 6)) queue_item(REQ_TICK, 8'($urandom));
            end else if (pick < 95) begin
                queue_item(REQ_TAKE, 8'($urandom));
            end else if (pick < 97) begin
                queue_item(REQ_UNUSED, 8'($urandom));
            end else begin
                repeat ($urandom_range(1, 4)) queue_item(REQ_BYTE, 8'($urandom));
            end
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Wait until every queued item has come back, then let the pipeline drain
    task automatic settle();
        while (req_backlog.size() != 0 || s_axis_tvalid || due_reports.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin : stimulus
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: take before any frame, unused code, a tick, a frame with
        // extreme field values, two takes, then a broken second header.
        queue_item(REQ_TAKE, 8'h00);
        queue_item(REQ_UNUSED, 8'hFF);
        queue_item(REQ_TICK, 8'hAA);
        queue_frame({8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'h00, 8'h80, 8'hFF, 8'h00},
                    1'b0, PAYLOAD_N);
        queue_item(REQ_TAKE, 8'h55);
        queue_item(REQ_TAKE, 8'h00);
        queue_item(REQ_BYTE, hdr1);
        queue_item(REQ_BYTE, hdr1);
        queue_item(REQ_BYTE, hdr2);
        settle();

        // Zero limit: the first tick already times the link out
        write_reg(CFG_TIMEOUT, 16'd0);
        queue_item(REQ_TICK, 8'h00);
        queue_item(REQ_TICK, 8'hFF);
        queue_item(REQ_TAKE, 8'h00);
        queue_random(120);
        settle();

        // Extreme headers, shortest nonzero limit, long stall on the result side
        write_reg(CFG_HDR_FIRST, 16'h0000);
        write_reg(CFG_HDR_SECOND, 16'h00FF);
        write_reg(CFG_TIMEOUT, 16'd1);
        queue_random(170);
        hold_requests++;
        settle();

        // Swapped extremes, steady source
        write_reg(CFG_HDR_FIRST, 16'h00FF);
        write_reg(CFG_HDR_SECOND, 16'h0000);
        write_reg(CFG_TIMEOUT, 16'd3);
        src_calm = 1'b1;
        queue_random(170);
        settle();

        // Equal headers, largest limit, no idling on either side, another hold
        write_reg(CFG_HDR_FIRST, 16'h007E);
        write_reg(CFG_HDR_SECOND, 16'h007E);
        write_reg(CFG_TIMEOUT, 16'hFFFF);
        sink_calm = 1'b1;
        queue_random(170);
        hold_requests++;
        settle();

        // Random headers and a short limit, random idling again
        write_reg(CFG_HDR_FIRST, 16'($urandom_range(0, 255)));
        write_reg(CFG_HDR_SECOND, 16'($urandom_range(0, 255)));
        write_reg(CFG_TIMEOUT, 16'($urandom_range(2, 12)));
        src_calm  = 1'b0;
        sink_calm = 1'b0;
        queue_random(200);
        settle();
        repeat (10) @(posedge i_clk);

        $display("Checked %0d results for %0d items across six register settings",
                 results_seen, queued);
        $display("Events: %0d frames, %0d CRC errors, %0d timeouts, %0d task switches",
                 ev_seen[EV_FRAME], ev_seen[EV_CRC_ERR], ev_seen[EV_TIMEOUT], sw_count);
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
